// ----- sv/bmp_pkg.sv -----
// Package for the BMP pixel stream decoder: item and result structs,
// action, mode and register codes, and the palette memory request bundle.
// No dependencies.
`default_nettype none

package bmp_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam logic [12:0] MAX_DIMENSION = 13'd4096;

  // Action codes carried by an input item.
  localparam logic [1:0] ACT_PAL_WRITE = 2'd0;
  localparam logic [1:0] ACT_PIXEL     = 2'd1;
  localparam logic [1:0] ACT_BEGIN     = 2'd2;

  // Depth modes.
  localparam logic [1:0] MODE_PAL8   = 2'd0;
  localparam logic [1:0] MODE_RGB565 = 2'd1;
  localparam logic [1:0] MODE_BGR24  = 2'd2;
  localparam logic [1:0] MODE_WORD32 = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEPTH_MODE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  palette_index;
    logic [31:0] palette_value;
    logic [7:0]  data_byte;
  } src_item_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        last_pixel;
  } pix_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [PAL_AW-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [PAL_AW-1:0] rd_addr;
  } pal_req_t;

endpackage

`default_nettype wire

// ----- sv/bmp_palette.sv -----
// Palette memory of the BMP decoder: one write port and one registered
// read port. Uses bmp_pkg.
`default_nettype none

module bmp_palette (
  input  wire logic             clk,
  input  wire bmp_pkg::pal_req_t req,
  output logic [31:0]           rd_data
);
  import bmp_pkg::*;

  logic [31:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/bmp_pixel_stream_decoder.sv -----
// Top level of the BMP pixel stream decoder: byte assembly, row and column
// counters, result pipeline. Uses bmp_pkg and bmp_palette.
`default_nettype none

// The decoder takes one item per clock: palette writes, pixel data bytes and
// begin marks. It keeps up that rate indefinitely as long as results are
// taken; a result goes from the byte that completed it to the palette-read
// stage, the registered read of the palette memory, which every pixel passes
// through so that all modes share one path, and then to the output register.
// Input is stalled only while both the palette-read stage and the output
// register are full and the output is stalled. Configuration writes are
// always ready and take effect at once; the palette needs no clearing pass.
module bmp_pixel_stream_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 src_valid,
  output logic                      src_stall,
  input  wire bmp_pkg::src_item_t   src_item,
  output logic                      pix_valid,
  input  wire logic                 pix_stall,
  output bmp_pkg::pix_item_t        pix_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [12:0]          cfg_data
);
  import bmp_pkg::*;

  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > MAX_DIMENSION) begin
      r = MAX_DIMENSION;
    end
    return r;
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // Configuration registers.
  logic [1:0]  depth_mode;
  logic [12:0] image_width;
  logic [12:0] image_height;

  // Decode state.
  logic [23:0] byte_gather, byte_gather_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [11:0] column_count, column_count_next;
  logic [11:0] row_count, row_count_next;
  logic [1:0]  pad_remaining, pad_remaining_next;
  logic        image_done, image_done_next;

  // Palette-read stage and output register.
  logic        s2_valid;
  logic        s2_pal;
  pix_item_t   s2_item;
  logic        s2_move;
  logic        src_fire;
  logic        emit;
  pix_item_t   emit_item;
  logic [31:0] pal_data;
  pal_req_t    pal_req;

  // Combinational per-byte values.
  logic [2:0]  bpp;
  logic [12:0] w, h;
  logic [12:0] col_inc, row_inc;
  logic        row_end, last;
  logic [15:0] rgb;
  logic [1:0]  row_bytes_lo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode   <= MODE_PAL8;
      image_width  <= 13'd640;
      image_height <= 13'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEPTH_MODE:   depth_mode   <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s2_move   = s2_valid && (!pix_valid || !pix_stall);
  assign src_stall = s2_valid && !s2_move;
  assign src_fire  = src_valid && !src_stall;

  assign bpp     = {1'b0, depth_mode} + 3'd1;
  assign w       = clamp_dim(image_width);
  assign h       = clamp_dim(image_height);
  assign col_inc = {1'b0, column_count} + 13'd1;
  assign row_inc = {1'b0, row_count} + 13'd1;
  assign row_end = col_inc >= w;
  assign last    = row_end && (row_inc >= h);
  assign rgb     = {src_item.data_byte, byte_gather[7:0]};
  // Only the low two bits of width times bytes per pixel set the padding.
  assign row_bytes_lo = 2'(w[1:0] * bpp[1:0]);

  always_comb begin
    byte_gather_next   = byte_gather;
    byte_position_next = byte_position;
    column_count_next  = column_count;
    row_count_next     = row_count;
    pad_remaining_next = pad_remaining;
    image_done_next    = image_done;
    emit               = 1'b0;
    emit_item          = '0;

    emit_item.pixel_column = column_count;
    emit_item.pixel_row    = ({1'b0, row_count} < (h - 13'd1)) ?
                             12'(h - 13'd1 - {1'b0, row_count}) : 12'd0;
    emit_item.last_pixel   = last;
    unique case (depth_mode)
      MODE_RGB565: emit_item.pixel_color = {8'd0, widen5(rgb[15:11]),
                                            widen6(rgb[10:5]), widen5(rgb[4:0])};
      MODE_BGR24:  emit_item.pixel_color = {8'd0, src_item.data_byte,
                                            byte_gather[15:0]};
      MODE_WORD32: emit_item.pixel_color = {src_item.data_byte, byte_gather};
      default:     emit_item.pixel_color = 32'd0;
    endcase

    if (src_fire) begin
      if (src_item.action == ACT_BEGIN) begin
        byte_gather_next   = '0;
        byte_position_next = '0;
        column_count_next  = '0;
        row_count_next     = '0;
        pad_remaining_next = '0;
        image_done_next    = 1'b0;
      end else if (src_item.action == ACT_PIXEL && !image_done) begin
        if (pad_remaining != 2'd0) begin
          pad_remaining_next = pad_remaining - 2'd1;
        end else if ({1'b0, byte_position} + 3'd1 < bpp) begin
          unique case (byte_position)
            2'd0:    byte_gather_next[7:0]   = byte_gather[7:0]   | src_item.data_byte;
            2'd1:    byte_gather_next[15:8]  = byte_gather[15:8]  | src_item.data_byte;
            2'd2:    byte_gather_next[23:16] = byte_gather[23:16] | src_item.data_byte;
            default: ;
          endcase
          byte_position_next = byte_position + 2'd1;
        end else begin
          emit               = 1'b1;
          byte_gather_next   = '0;
          byte_position_next = '0;
          if (row_end) begin
            column_count_next = '0;
            if (last) begin
              image_done_next = 1'b1;
            end else begin
              row_count_next     = row_count + 12'd1;
              pad_remaining_next = 2'd0 - row_bytes_lo;
            end
          end else begin
            column_count_next = column_count + 12'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_gather   <= '0;
      byte_position <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_remaining <= '0;
      image_done    <= 1'b0;
    end else begin
      byte_gather   <= byte_gather_next;
      byte_position <= byte_position_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      pad_remaining <= pad_remaining_next;
      image_done    <= image_done_next;
    end
  end

  // A palette write lands at the edge it is accepted, so a later read of the
  // same entry, even in the next cycle, already sees it.
  always_comb begin
    pal_req.wr_en   = src_fire && (src_item.action == ACT_PAL_WRITE);
    pal_req.wr_addr = src_item.palette_index;
    pal_req.wr_data = src_item.palette_value;
    pal_req.rd_en   = src_fire && (src_item.action == ACT_PIXEL);
    pal_req.rd_addr = src_item.data_byte;
  end

  bmp_palette u_palette (
    .clk     (clk),
    .req     (pal_req),
    .rd_data (pal_data)
  );

  // The read data only changes when an item is accepted, and that happens
  // only when this stage is empty or moving on, so it holds while waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (src_fire) begin
      s2_valid <= emit;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire && emit) begin
      s2_item <= emit_item;
      s2_pal  <= (depth_mode == MODE_PAL8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s2_move) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      pix_item <= {(s2_pal ? pal_data : s2_item.pixel_color), s2_item.pixel_column,
                   s2_item.pixel_row, s2_item.last_pixel};
    end
  end

endmodule

`default_nettype wire

// ----- bench/pixel_check_pkg.sv -----
// Scoreboard for the BMP pixel stream decoder bench: predicts decoded pixels
// from accepted items and compares them with the block's results.
// Depends on bmp_pkg.
`timescale 1ns / 1ps

package pixel_check_pkg;
  import bmp_pkg::*;

  class pixel_scoreboard;
    logic [1:0]  depth_mode;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [31:0] palette_mem [PALETTE_ENTRIES];
    logic [23:0] gather;
    logic [1:0]  gather_pos;
    int          column_cnt;
    int          row_cnt;
    int          pad_left;
    bit          image_done;
    pix_item_t   expected_q[$];
    int          errors;

    function new();
      depth_mode = MODE_PAL8;
      width_reg  = 13'd640;
      height_reg = 13'd480;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      gather     = '0;
      gather_pos = '0;
      column_cnt = 0;
      row_cnt    = 0;
      pad_left   = 0;
      image_done = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        REG_DEPTH_MODE:   depth_mode = val[1:0];
        REG_IMAGE_WIDTH:  width_reg = val;
        REG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function int clamp_dim(logic [12:0] v);
      if (v == 13'd0) return 1;
      if (v > MAX_DIMENSION) return int'(MAX_DIMENSION);
      return int'(v);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(src_item_t it);
      int          bpp;
      int          w;
      int          h;
      int          stored_row;
      logic [15:0] rgb565;
      logic [31:0] color;
      pix_item_t   px;
      if (it.action == ACT_PAL_WRITE) begin
        palette_mem[it.palette_index] = it.palette_value;
        return;
      end
      if (it.action == ACT_BEGIN) begin
        restart();
        return;
      end
      if (it.action != ACT_PIXEL || image_done) return;
      if (pad_left > 0) begin
        pad_left--;
        return;
      end
      bpp = int'(depth_mode) + 1;
      if (int'(gather_pos) + 1 < bpp) begin
        gather = gather | (24'(it.data_byte) << (8 * gather_pos));
        gather_pos++;
        return;
      end
      case (depth_mode)
        MODE_PAL8: color = palette_mem[it.data_byte];
        MODE_RGB565: begin
          // Each channel is widened by repeating its top bits below it.
          rgb565 = {it.data_byte, gather[7:0]};
          color = {8'h00, rgb565[15:11], rgb565[15:13], rgb565[10:5], rgb565[10:9],
                   rgb565[4:0], rgb565[4:2]};
        end
        MODE_BGR24: color = {8'h00, it.data_byte, gather[15:0]};
        default: color = {it.data_byte, gather};
      endcase
      gather     = '0;
      gather_pos = '0;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      stored_row = (row_cnt < h - 1) ? h - 1 - row_cnt : 0;
      px.pixel_color  = color;
      px.pixel_column = 12'(column_cnt);
      px.pixel_row    = 12'(stored_row);
      px.last_pixel   = (column_cnt + 1 >= w) && (row_cnt + 1 >= h);
      expected_q.push_back(px);
      if (column_cnt + 1 >= w) begin
        column_cnt = 0;
        if (px.last_pixel) begin
          image_done = 1'b1;
        end else begin
          row_cnt++;
          pad_left = (-(w * bpp)) & 3;
        end
      end else begin
        column_cnt++;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pix_item_t got);
      pix_item_t want;
      if (expected_q.size() == 0) begin
        $error("pixel result with nothing expected: %0h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("pixel_color", want.pixel_color, got.pixel_color);
      compare_field("pixel_column", 32'(want.pixel_column), 32'(got.pixel_column));
      compare_field("pixel_row", 32'(want.pixel_row), 32'(got.pixel_row));
      compare_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
    endfunction
  endclass

endpackage

// ----- bench/tb.sv -----
// Top-level bench for bmp_pixel_stream_decoder: drives palette, pixel and
// begin items with random gaps and output stalls, and checks every pixel.
// Depends on bmp_pkg and pixel_check_pkg.
`timescale 1ns / 1ps

module tb;
  import bmp_pkg::*;
  import pixel_check_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        src_valid;
  logic        src_stall;
  src_item_t   src_item;
  logic        pix_valid;
  logic        pix_stall;
  pix_item_t   pix_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  pixel_scoreboard board;
  bit              pal_written [PALETTE_ENTRIES];
  int              written_idx[$];
  logic [1:0]      cur_mode;
  bit              squeeze_req;
  bit              gaps_on;
  int              burst_left;
  int              items_sent;

  bmp_pixel_stream_decoder dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && !pix_stall) board.check_pixel(pix_item);
      if (src_valid && !src_stall) board.note_item(src_item);
    end
  end

  // Output side: changes its stall pattern every so often, and holds off
  // for a long stretch whenever the stimulus asks for it.
  initial begin
    int style;
    int span;
    int hold;
    int tick;
    pix_stall = 1'b0;
    style = 0;
    span = 0;
    hold = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = 200;
      end
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span = $urandom_range(20, 150);
      end
      span--;
      if (hold > 0) begin
        hold--;
        pix_stall <= 1'b1;
      end else begin
        case (style)
          0: pix_stall <= 1'b0;
          1: pix_stall <= ($urandom_range(0, 3) == 0);
          2: pix_stall <= ($urandom_range(0, 1) == 0);
          default: pix_stall <= (tick % 5 < 3);
        endcase
      end
    end
  end

  function automatic src_item_t make_item(logic [1:0] act);
    src_item_t it;
    it.action        = act;
    it.palette_index = 8'($urandom);
    it.palette_value = $urandom;
    it.data_byte     = 8'($urandom);
    return it;
  endfunction

  // In palette mode any byte may be looked up, so only written entries are used.
  function automatic logic [7:0] next_byte();
    if (cur_mode == MODE_PAL8) return 8'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
    return 8'($urandom);
  endfunction

  task automatic send_item(src_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          src_valid <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk);
    src_valid <= 1'b1;
    src_item  <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    if (it.action != ACT_UNUSED) items_sent++;
  endtask

  task automatic send_data(logic [7:0] b);
    src_item_t it;
    it = make_item(ACT_PIXEL);
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_palette(logic [7:0] idx, logic [31:0] val);
    src_item_t it;
    it = make_item(ACT_PAL_WRITE);
    it.palette_index = idx;
    it.palette_value = val;
    if (!pal_written[idx]) begin
      pal_written[idx] = 1'b1;
      written_idx.push_back(int'(idx));
    end
    send_item(it);
  endtask

  task automatic send_begin();
    send_item(make_item(ACT_BEGIN));
  endtask

  task automatic send_noise();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) send_palette(8'($urandom), $urandom);
    else if (pick < 9) send_item(make_item(ACT_UNUSED));
    else send_begin();
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only once every pending pixel is out and a settling wait
  // has passed.
  task automatic set_config(logic [1:0] mode, logic [12:0] wreg, logic [12:0] hreg);
    @(negedge clk);
    src_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_DEPTH_MODE, 13'(mode));
    write_reg(REG_IMAGE_WIDTH, wreg);
    write_reg(REG_IMAGE_HEIGHT, hreg);
    cur_mode = mode;
  endtask

  function automatic logic [12:0] pick_dim(int common_max);
    case ($urandom_range(0, 11))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom_range(4097, 8191));
      3: return 13'd8191;
      default: return 13'($urandom_range(1, common_max));
    endcase
  endfunction

  task automatic run_image(logic [1:0] mode, logic [12:0] wreg, logic [12:0] hreg,
                           bit fresh, bit squeeze, int max_pix);
    int ew;
    int eh;
    int npix;
    int bpp;
    int pad;
    set_config(mode, wreg, hreg);
    if (squeeze) squeeze_req = 1'b1;
    if (fresh) send_begin();
    ew = (wreg == 0) ? 1 : (wreg > 4096) ? 4096 : int'(wreg);
    eh = (hreg == 0) ? 1 : (hreg > 4096) ? 4096 : int'(hreg);
    npix = ew * eh;
    if (npix > max_pix) npix = max_pix;
    bpp = int'(mode) + 1;
    pad = (-(ew * bpp)) & 3;
    for (int p = 0; p < npix; p++) begin
      if ($urandom_range(0, 19) == 0) send_noise();
      repeat (bpp) send_data(next_byte());
      if (p % ew == ew - 1) repeat (pad) send_data(next_byte());
    end
    // Trailing bytes are dropped if the image is complete, else decoded as more of it.
    repeat ($urandom_range(0, 3)) send_data(next_byte());
  endtask

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          wait_cycles;
    int          phase;
    logic [1:0]  mode;
    board = new();
    rst = 1'b1;
    src_valid = 1'b0;
    src_item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEPTH_MODE;
    cfg_data = '0;
    cur_mode = MODE_PAL8;
    gaps_on = 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Palette mode, 3x2 image: extreme entries, a pad byte after the first row,
    // a byte after the image and an unused action.
    set_config(MODE_PAL8, 13'd3, 13'd2);
    send_palette(8'h00, 32'h0000_0000);
    send_palette(8'hFF, 32'hFFFF_FFFF);
    send_palette(8'h5A, 32'hA5C3_3C5A);
    send_begin();
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h5A);
    send_data(8'h77);
    send_data(8'h5A);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hFF);
    send_item(make_item(ACT_UNUSED));

    // RGB565 white and black.
    set_config(MODE_RGB565, 13'd2, 13'd1);
    send_begin();
    send_data(8'hFF);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'h00);

    // One 32-bit word.
    set_config(MODE_WORD32, 13'd1, 13'd1);
    send_begin();
    send_data(8'h01);
    send_data(8'h80);
    send_data(8'h7F);
    send_data(8'hFE);

    phase = 0;
    while (items_sent < 2020) begin
      phase++;
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase % 9 == 4) begin
        gaps_on = 1'b0;
        run_image(MODE_PAL8, 13'd8, 13'd8, 1'b1, 1'b1, 64);
      end else begin
        mode = 2'($urandom_range(0, 3));
        run_image(mode, pick_dim(7), pick_dim(4), ($urandom_range(0, 7) != 0), 1'b0, 40);
      end
    end

    @(negedge clk);
    src_valid <= 1'b0;
    wait_cycles = 0;
    while (board.pending() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (board.pending() != 0) begin
      $error("%0d expected pixels never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
